// ----- hdl/i2a_pkg.sv -----
package i2a_pkg;

	localparam int unsigned BIN_W  = 32;
	localparam int unsigned NDIG   = 10;            // decimal digits of a 32-bit magnitude
	localparam int unsigned DIG_W  = 4 * NDIG;
	localparam int unsigned DCNT_W = 4;
	localparam int unsigned CHAR_W = 8;
	localparam int unsigned FW_W   = 6;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_UPPER = 8'h41;
	localparam logic [CHAR_W-1:0] CH_LOWER = 8'h61;
	localparam logic [3:0]        RADIX10  = 4'd10;

	typedef enum logic [1:0] {
		SEL_MINUS,
		SEL_PAD,
		SEL_DIGIT
	} ch_sel_t;

	typedef struct packed {
		logic              load;       // capture a new word
		logic              step;       // one double-dabble step
		logic              emit;       // write one character to the output register
		ch_sel_t           sel;
		logic [DCNT_W-1:0] digit_idx;
		logic              last;
	} i2a_cmd_t;

	typedef struct packed {
		logic              out_free;
		logic              early_sign; // minus goes ahead of zero padding
		logic              text_sign;  // minus sits just before the digits
		logic              right;
		logic [DCNT_W-1:0] ndig;
	} i2a_sts_t;

endpackage

// ----- hdl/integer_to_ascii_formatter_core.sv -----
// Integer to ASCII formatter (printf-style %d / %u / %x / %X with width and padding).
//
// Input channel (in_valid/in_ready): one word per conversion: value, base_hex, is_signed,
// upper_case, field_width, pad_mode. in_ready is high only while no conversion is running.
// Output channel (out_valid/out_ready): one ASCII character per word, last set on the final
// character. The count is max(text length, saturated field_width), 1 to MAX_WIDTH.
//
// Sequence: decimal runs a bit-serial double-dabble over the 32 magnitude bits, then a
// sizing state; hex skips the conversion and goes straight to sizing. Characters then
// leave at one per cycle from a single output register while out_ready stays high. A new
// word can be accepted as soon as the last character sits in the output register.
//
// A stalled receiver (out_ready low) holds the output register and the sequencer emits no
// further character until it drains; nothing is dropped.
// Reset (arst_n low) returns the sequencer to idle and clears out_valid; any conversion in
// flight is discarded.
module integer_to_ascii_formatter_core import i2a_pkg::*; #(
	parameter int unsigned MAX_WIDTH = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [BIN_W-1:0] value,
	input  logic                    base_hex,
	input  logic                    is_signed,
	input  logic                    upper_case,
	input  logic [FW_W-1:0]         field_width,
	input  logic [1:0]              pad_mode,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [CHAR_W-1:0]       character,
	output logic                    last
);

	localparam int unsigned PW = $clog2(MAX_WIDTH + 1);

	i2a_cmd_t      cmd;
	i2a_sts_t      sts;
	logic [PW-1:0] pad_cnt;

	i2a_ctrl #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.base_hex (base_hex),
		.sts      (sts),
		.pad_cnt  (pad_cnt),
		.cmd      (cmd)
	);

	i2a_dpath #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.value       (value),
		.base_hex    (base_hex),
		.is_signed   (is_signed),
		.upper_case  (upper_case),
		.field_width (field_width),
		.pad_mode    (pad_mode),
		.cmd         (cmd),
		.sts         (sts),
		.pad_cnt     (pad_cnt),
		.character   (character),
		.last        (last),
		.out_valid   (out_valid),
		.out_ready   (out_ready)
	);

endmodule

// ----- hdl/i2a_ctrl.sv -----
module i2a_ctrl import i2a_pkg::*; #(
	parameter int unsigned MAX_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                base_hex,
	input  i2a_sts_t                            sts,
	input  logic [$clog2(MAX_WIDTH+1)-1:0]      pad_cnt,
	output i2a_cmd_t                            cmd
);

	localparam int unsigned PW = $clog2(MAX_WIDTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIZE,
		ST_SIGN,
		ST_LPAD,
		ST_TSIGN,
		ST_DIGIT,
		ST_RPAD
	} state_t;

	state_t            state_q;
	state_t            first_st;
	state_t            nxt_emit;
	logic [4:0]        bit_cnt_q;
	logic [PW-1:0]     pad_q;
	logic [DCNT_W-1:0] dig_q;
	logic              tsign_q;
	logic              right_q;
	logic              emitting;
	logic              emit_go;

	assign in_ready = (state_q == ST_IDLE);
	assign emitting = (state_q == ST_SIGN) || (state_q == ST_LPAD) || (state_q == ST_TSIGN) ||
	                  (state_q == ST_DIGIT) || (state_q == ST_RPAD);
	assign emit_go  = emitting && sts.out_free;

	always_comb begin
		if (sts.early_sign)
			first_st = ST_SIGN;
		else if (!sts.right && pad_cnt != '0)
			first_st = ST_LPAD;
		else if (sts.text_sign)
			first_st = ST_TSIGN;
		else
			first_st = ST_DIGIT;
	end

	// state that follows the character emitted now; idle means it was the last one
	always_comb begin
		case (state_q)
			ST_SIGN: begin
				nxt_emit = (!right_q && pad_q != '0) ? ST_LPAD : ST_DIGIT;
			end
			ST_LPAD: begin
				if (pad_q == PW'(1))
					nxt_emit = tsign_q ? ST_TSIGN : ST_DIGIT;
				else
					nxt_emit = ST_LPAD;
			end
			ST_TSIGN: begin
				nxt_emit = ST_DIGIT;
			end
			ST_DIGIT: begin
				if (dig_q == DCNT_W'(1))
					nxt_emit = (right_q && pad_q != '0) ? ST_RPAD : ST_IDLE;
				else
					nxt_emit = ST_DIGIT;
			end
			ST_RPAD: begin
				nxt_emit = (pad_q == PW'(1)) ? ST_IDLE : ST_RPAD;
			end
			default: begin
				nxt_emit = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.load      = in_valid && in_ready;
		cmd.step      = (state_q == ST_CONV);
		cmd.emit      = emit_go;
		cmd.last      = (nxt_emit == ST_IDLE);
		cmd.digit_idx = dig_q - DCNT_W'(1);
		case (state_q)
			ST_SIGN, ST_TSIGN: cmd.sel = SEL_MINUS;
			ST_LPAD, ST_RPAD:  cmd.sel = SEL_PAD;
			default:           cmd.sel = SEL_DIGIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			bit_cnt_q <= '0;
			pad_q     <= '0;
			dig_q     <= '0;
			tsign_q   <= 1'b0;
			right_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						bit_cnt_q <= 5'd31;
						state_q   <= base_hex ? ST_SIZE : ST_CONV;
					end
				end
				ST_CONV: begin
					bit_cnt_q <= bit_cnt_q - 5'd1;
					if (bit_cnt_q == 5'd0)
						state_q <= ST_SIZE;
				end
				ST_SIZE: begin
					pad_q   <= pad_cnt;
					dig_q   <= sts.ndig;
					tsign_q <= sts.text_sign;
					right_q <= sts.right;
					state_q <= first_st;
				end
				default: begin
					if (emit_go) begin
						if (state_q == ST_LPAD || state_q == ST_RPAD)
							pad_q <= pad_q - PW'(1);
						if (state_q == ST_DIGIT)
							dig_q <= dig_q - DCNT_W'(1);
						state_q <= nxt_emit;
					end
				end
			endcase
		end
	end

endmodule

// ----- hdl/i2a_dpath.sv -----
module i2a_dpath import i2a_pkg::*; #(
	parameter int unsigned MAX_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic signed [BIN_W-1:0]             value,
	input  logic                                base_hex,
	input  logic                                is_signed,
	input  logic                                upper_case,
	input  logic [FW_W-1:0]                     field_width,
	input  logic [1:0]                          pad_mode,
	input  i2a_cmd_t                            cmd,
	output i2a_sts_t                            sts,
	output logic [$clog2(MAX_WIDTH+1)-1:0]      pad_cnt,
	output logic [CHAR_W-1:0]                   character,
	output logic                                last,
	output logic                                out_valid,
	input  logic                                out_ready
);

	localparam int unsigned PW = $clog2(MAX_WIDTH + 1);
	localparam int unsigned CW = (PW > FW_W) ? PW : FW_W;

	logic [BIN_W-1:0]  mag_q;
	logic [DIG_W-1:0]  dig_q;
	logic              neg_q;
	logic              upper_q;
	logic              zeros_q;
	logic              right_q;
	logic [PW-1:0]     width_q;
	logic [CHAR_W-1:0] character_q;
	logic              last_q;
	logic              out_valid_q;

	logic [BIN_W-1:0]  raw;
	logic              neg_in;
	logic [PW-1:0]     width_sat;
	logic [DIG_W-1:0]  adj;
	logic [DCNT_W-1:0] ndig;
	logic              early;
	logic              tsign;
	logic [DCNT_W-1:0] tlen;
	logic [PW-1:0]     w2;
	logic [3:0]        dsel;
	logic [CHAR_W-1:0] ch;

	assign raw    = value;
	assign neg_in = is_signed && !base_hex && raw[BIN_W-1];

	always_comb begin
		if (CW'(field_width) > CW'(MAX_WIDTH))
			width_sat = PW'(MAX_WIDTH);
		else
			width_sat = PW'(field_width);
	end

	// add-3 correction on every BCD nibble ahead of the shift
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			if (dig_q[4*i +: 4] >= 4'd5)
				adj[4*i +: 4] = dig_q[4*i +: 4] + 4'd3;
			else
				adj[4*i +: 4] = dig_q[4*i +: 4];
		end
	end

	// digit count, at least one so that zero prints as a single '0'
	always_comb begin
		ndig = DCNT_W'(1);
		for (int i = 1; i < NDIG; i++) begin
			if (dig_q[4*i +: 4] != 4'd0)
				ndig = DCNT_W'(i + 1);
		end
	end

	assign early   = neg_q && zeros_q && (width_q != '0);
	assign tsign   = neg_q && !early;
	assign tlen    = ndig + DCNT_W'(tsign);
	assign w2      = width_q - PW'(early);
	assign pad_cnt = (w2 > PW'(tlen)) ? (w2 - PW'(tlen)) : '0;

	assign sts.out_free   = !out_valid_q || out_ready;
	assign sts.early_sign = early;
	assign sts.text_sign  = tsign;
	assign sts.right      = right_q;
	assign sts.ndig       = ndig;

	assign dsel = dig_q[4*cmd.digit_idx +: 4];

	always_comb begin
		case (cmd.sel)
			SEL_MINUS: ch = CH_MINUS;
			SEL_PAD:   ch = zeros_q ? CH_ZERO : CH_SPACE;
			SEL_DIGIT: begin
				if (dsel < RADIX10)
					ch = CH_ZERO + CHAR_W'(dsel);
				else
					ch = (upper_q ? CH_UPPER : CH_LOWER) + CHAR_W'(dsel - RADIX10);
			end
			default:   ch = CH_SPACE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q   <= neg_in ? (BIN_W'(0) - raw) : raw;
			dig_q   <= base_hex ? DIG_W'(raw) : '0;
			neg_q   <= neg_in;
			upper_q <= upper_case;
			zeros_q <= pad_mode[1];
			right_q <= pad_mode[0];
			width_q <= width_sat;
		end else if (cmd.step) begin
			dig_q <= {adj[DIG_W-2:0], mag_q[BIN_W-1]};
			mag_q <= {mag_q[BIN_W-2:0], 1'b0};
		end
		if (cmd.emit) begin
			character_q <= ch;
			last_q      <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign character = character_q;
	assign last      = last_q;
	assign out_valid = out_valid_q;

endmodule

// ----- hdl/i2a_chk.sv -----
module i2a_chk import i2a_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [CHAR_W-1:0] character,
	input logic              last
);

	// stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(character) && $stable(last))
		else $error("output word changed while stalled");

	// one conversion at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted twice in a row");

	// no new word while a conversion still has characters to send
	a_no_accept_mid_text: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !in_ready)
		else $error("input ready in the middle of a conversion");

	// characters of one conversion follow back to back
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid)
		else $error("gap inside a conversion");

endmodule

bind integer_to_ascii_formatter_core i2a_chk u_i2a_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.character (character),
	.last      (last)
);

// ----- sim/tb_top.sv -----
module tb_top;
	import i2a_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned MAX_WIDTH  = 32;
	localparam int unsigned IDLE_LIMIT = 1000;
	localparam int unsigned TAIL_WAIT  = 80;
	localparam int unsigned N_RANDOM   = 145;
	localparam int unsigned CALM_ITEMS = 25;

	typedef struct {
		logic signed [BIN_W-1:0] value;
		logic                    base_hex;
		logic                    is_signed;
		logic                    upper_case;
		logic [FW_W-1:0]         field_width;
		logic [1:0]              pad_mode;
	} conv_req_t;

	typedef struct {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} out_char_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic signed [BIN_W-1:0] value = '0;
	logic                    base_hex = 1'b0;
	logic                    is_signed = 1'b0;
	logic                    upper_case = 1'b0;
	logic [FW_W-1:0]         field_width = '0;
	logic [1:0]              pad_mode = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [CHAR_W-1:0]       character;
	logic                    last;

	conv_req_t   conv_queue[$];
	out_char_t   chars_due[$];
	int unsigned errors = 0;
	logic        calm = 1'b0;
	int unsigned idle_cycles = 0;

	integer_to_ascii_formatter_core #(
		.MAX_WIDTH (MAX_WIDTH)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.value       (value),
		.base_hex    (base_hex),
		.is_signed   (is_signed),
		.upper_case  (upper_case),
		.field_width (field_width),
		.pad_mode    (pad_mode),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.character   (character),
		.last        (last)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Expected character stream of one conversion, appended to chars_due
	function automatic void format_text(input conv_req_t r);
		logic [BIN_W-1:0]  mag;
		logic [CHAR_W-1:0] digits[$];
		logic [CHAR_W-1:0] line[$];
		logic [CHAR_W-1:0] pad;
		int unsigned       width;
		int unsigned       radix;
		int unsigned       d;
		logic              neg;
		out_char_t         c;

		width = (r.field_width > MAX_WIDTH) ? MAX_WIDTH : r.field_width;
		radix = r.base_hex ? 16 : 10;
		mag   = r.value;
		neg   = 1'b0;
		pad   = CH_SPACE;

		if (mag == '0) begin
			digits.push_front(CH_ZERO);
		end else begin
			if (r.is_signed && !r.base_hex && mag[BIN_W-1]) begin
				neg = 1'b1;
				mag = -mag;
			end
			while (mag != '0) begin
				d   = mag % radix;
				mag = mag / radix;
				if (d >= 10)
					digits.push_front((r.upper_case ? CH_UPPER : CH_LOWER) + CHAR_W'(d - 10));
				else
					digits.push_front(CH_ZERO + CHAR_W'(d));
			end
			if (neg) begin
				// zero padding with a width: sign leads and takes one column
				if (width != 0 && r.pad_mode[1]) begin
					line.push_back(CH_MINUS);
					width--;
				end else begin
					digits.push_front(CH_MINUS);
				end
			end
		end

		if (width > 0) begin
			width = (digits.size() >= width) ? 0 : width - digits.size();
			if (r.pad_mode[1])
				pad = CH_ZERO;
		end

		if (!r.pad_mode[0])
			repeat (width) line.push_back(pad);
		foreach (digits[i])
			line.push_back(digits[i]);
		if (r.pad_mode[0])
			repeat (width) line.push_back(pad);

		foreach (line[i]) begin
			c.ch   = line[i];
			c.last = (i == line.size() - 1);
			chars_due.push_back(c);
		end
	endfunction

	task automatic queue_conversion(input logic [BIN_W-1:0] v, input logic hex,
			input logic sgn, input logic upper, input logic [FW_W-1:0] fw,
			input logic [1:0] pm);
		conv_req_t r;

		r.value       = v;
		r.base_hex    = hex;
		r.is_signed   = sgn;
		r.upper_case  = upper;
		r.field_width = fw;
		r.pad_mode    = pm;
		conv_queue.push_back(r);
	endtask

	// Driver: one word per conversion, random gaps between words
	int unsigned gap = 0;
	int unsigned run = 0;
	always @(posedge clk or negedge arst_n) begin
		conv_req_t r;

		if (!arst_n) begin
			in_valid <= 1'b0;
			gap = 0;
			run = 0;
		end else begin
			if (in_valid && in_ready) begin
				r.value       = value;
				r.base_hex    = base_hex;
				r.is_signed   = is_signed;
				r.upper_case  = upper_case;
				r.field_width = field_width;
				r.pad_mode    = pad_mode;
				format_text(r);
			end
			calm <= (conv_queue.size() < CALM_ITEMS);
			if (!in_valid || in_ready) begin
				if (gap != 0) begin
					gap--;
					in_valid <= 1'b0;
				end else if (conv_queue.size() == 0) begin
					in_valid <= 1'b0;
				end else if (!calm && run == 0) begin
					gap = $urandom_range(1, 10) - 1;
					run = $urandom_range(0, 6);
					in_valid <= 1'b0;
				end else begin
					r = conv_queue.pop_front();
					value       <= r.value;
					base_hex    <= r.base_hex;
					is_signed   <= r.is_signed;
					upper_case  <= r.upper_case;
					field_width <= r.field_width;
					pad_mode    <= r.pad_mode;
					in_valid    <= 1'b1;
					if (run != 0)
						run--;
				end
			end
		end
	end

	// Monitor: checks each character word, stalls the output in bursts
	int unsigned stall = 0;
	int unsigned flow = 0;
	always @(posedge clk or negedge arst_n) begin
		out_char_t c;

		if (!arst_n) begin
			out_ready <= 1'b0;
			stall = 0;
			flow = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (chars_due.size() == 0) begin
					$error("unexpected character %h last %b", character, last);
					errors++;
				end else begin
					c = chars_due.pop_front();
					if (character !== c.ch) begin
						$error("character: expected %h, got %h", c.ch, character);
						errors++;
					end
					if (last !== c.last) begin
						$error("last: expected %b, got %b", c.last, last);
						errors++;
					end
				end
			end
			if (stall != 0) begin
				stall--;
				out_ready <= 1'b0;
			end else if (!calm && flow == 0) begin
				stall = $urandom_range(1, 10) - 1;
				flow = $urandom_range(0, 40);
				out_ready <= 1'b0;
			end else begin
				if (flow != 0)
					flow--;
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	initial begin
		logic [BIN_W-1:0] v;
		logic [FW_W-1:0]  fw;

		// directed: zero, extremes, every pad mode, saturation, overflow of width
		queue_conversion(32'd0, 1'b0, 1'b1, 1'b0, 6'd0, 2'd0);
		queue_conversion(32'd0, 1'b1, 1'b0, 1'b1, 6'd4, 2'd2);
		queue_conversion(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 6'd0, 2'd0);
		queue_conversion(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 6'd0, 2'd0);
		queue_conversion(32'h8000_0000, 1'b0, 1'b1, 1'b0, 6'd0, 2'd0);
		queue_conversion(32'h8000_0000, 1'b0, 1'b1, 1'b0, 6'd14, 2'd2);
		queue_conversion(32'h7FFF_FFFF, 1'b0, 1'b1, 1'b0, 6'd0, 2'd0);
		queue_conversion(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1, 6'd0, 2'd0);
		queue_conversion(32'hABCD_EF12, 1'b1, 1'b0, 1'b0, 6'd10, 2'd0);
		queue_conversion(32'hABCD_EF12, 1'b1, 1'b0, 1'b1, 6'd10, 2'd1);
		queue_conversion(32'h8000_0000, 1'b1, 1'b1, 1'b0, 6'd0, 2'd2);
		for (int pm = 0; pm < 4; pm++) begin
			queue_conversion(-32'sd42, 1'b0, 1'b1, 1'b0, 6'd8, pm[1:0]);
			queue_conversion(32'd42, 1'b0, 1'b1, 1'b0, 6'd8, pm[1:0]);
		end
		queue_conversion(-32'sd5, 1'b0, 1'b1, 1'b0, 6'd1, 2'd2);
		queue_conversion(-32'sd5, 1'b0, 1'b1, 1'b0, 6'd0, 2'd2);
		queue_conversion(32'd123, 1'b0, 1'b0, 1'b0, 6'd63, 2'd0);
		queue_conversion(-32'sd7, 1'b0, 1'b1, 1'b0, 6'd32, 2'd3);
		queue_conversion(32'd1234567, 1'b0, 1'b0, 1'b0, 6'd3, 2'd2);
		queue_conversion(32'h1F, 1'b1, 1'b0, 1'b1, 6'd33, 2'd1);

		for (int n = 0; n < N_RANDOM; n++) begin
			case ($urandom_range(0, 5))
				0: v = $urandom_range(0, 20);
				1: v = -$urandom_range(1, 20);
				2: v = $urandom_range(0, 99999);
				3: v = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
				default: v = $urandom;
			endcase
			fw = FW_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) :
				$urandom_range(0, 16));
			queue_conversion(v, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), fw, 2'($urandom_range(0, 3)));
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (conv_queue.size() != 0 || in_valid || chars_due.size() != 0);
		repeat (TAIL_WAIT) @(posedge clk);

		if (chars_due.size() != 0) begin
			$error("%0d characters never arrived", chars_due.size());
			errors++;
		end
		if (errors == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/i2a_pkg.sv
hdl/i2a_ctrl.sv
hdl/i2a_dpath.sv
hdl/integer_to_ascii_formatter_core.sv
hdl/i2a_chk.sv
sim/tb_top.sv
